### hw/rtl/sldf_pkg.sv
// Shared types, status codes and the CRC-16-CCITT byte update for the packet deframer.
// No dependencies; used by sldf_core, the top level and the checker.
package sldf_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_NONE    = 3'd0,
        STATUS_GOOD    = 3'd1,
        STATUS_TOO_BIG = 3'd2,
        STATUS_BAD_CMP = 3'd3,
        STATUS_BAD_CRC = 3'd4
    } status_t;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;
    localparam logic [15:0] CRC_SEED         = 16'hFFFF;

    // Position counter value that means "prefix done"
    localparam logic [2:0] POS_BODY = 3'd5;

    // One result item
    typedef struct packed {
        logic        payload_valid;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [15:0] err_first;
        logic [15:0] err_second;
    } result_t;

    // CRC-16-CCITT (poly 0x1021, MSB first), one byte per call
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

### hw/rtl/sldf_in_stage.sv
// Input register of the packet deframer: holds one received byte until the core takes it.
// Depends on nothing but the clock and reset.
module sldf_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    output logic       in_valid,
    output logic [7:0] in_byte,
    input  logic       in_take
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Open for a new beat when empty or when the held byte moves on this cycle
    assign s_tready = !valid_reg || in_take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Capture the byte
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
        end
    end

endmodule

### hw/rtl/sldf_core.sv
// Deframer core: sync hunt, length prefix check, payload CRC and the result register.
// Depends on sldf_pkg for status codes, the result struct and the CRC update.
module sldf_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_take,
    input  logic                cfg_valid,
    input  logic [15:0]         cfg_data,
    output logic                res_valid,
    input  logic                res_ready,
    output sldf_pkg::result_t   res
);

    // Packet state
    logic [15:0] max_length_reg;
    logic        in_sync_reg,  in_sync_next;
    logic [2:0]  pos_reg,      pos_next;
    logic [7:0]  prefix_reg [0:3];
    logic [7:0]  prefix_next [0:3];
    logic [15:0] len_reg,      len_next;
    logic [15:0] count_reg,    count_next;
    logic [15:0] crc_reg,      crc_next;
    logic [7:0]  crc_lo_reg,   crc_lo_next;
    logic [1:0]  crc_cnt_reg,  crc_cnt_next;

    // Result register
    logic                res_valid_reg;
    sldf_pkg::result_t   res_reg, res_next;

    // Prefix decode
    logic [15:0] len_word;
    logic [15:0] cmp_word;
    logic [15:0] rx_crc;

    assign in_take   = in_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign len_word = {prefix_reg[2], prefix_reg[1]};
    assign cmp_word = {in_byte, prefix_reg[3]};
    assign rx_crc   = {in_byte, crc_lo_reg};

    // Next packet state and result for the byte being taken
    always_comb
    begin
        in_sync_next = in_sync_reg;
        pos_next     = pos_reg;
        for (int k = 0; k < 4; k++)
        begin
            prefix_next[k] = prefix_reg[k];
        end
        len_next     = len_reg;
        count_next   = count_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        crc_cnt_next = crc_cnt_reg;
        res_next     = '0;
        res_next.status = sldf_pkg::STATUS_NONE;

        if (!in_sync_reg)
        begin
            // Hunt for the zero sync byte
            if (in_byte != 8'h00)
            begin
                pos_next = 3'd0;
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    prefix_next[k] = 8'h00;
                end
                len_next     = 16'h0000;
                count_next   = 16'h0000;
                crc_next     = sldf_pkg::CRC_SEED;
                crc_lo_next  = 8'h00;
                crc_cnt_next = 2'd0;
                in_sync_next = 1'b1;
                pos_next     = 3'd1;
            end
        end
        else if (pos_reg < 3'd4)
        begin
            // Collect the prefix
            prefix_next[pos_reg[1:0]] = in_byte;
            pos_next = pos_reg + 3'd1;
        end
        else if (pos_reg == 3'd4)
        begin
            // Last prefix byte: check length against its complement
            len_next = len_word;
            if (len_word == ~cmp_word)
            begin
                if (len_word > max_length_reg)
                begin
                    res_next.status     = sldf_pkg::STATUS_TOO_BIG;
                    res_next.err_first  = len_word;
                    res_next.err_second = max_length_reg;
                    in_sync_next        = 1'b0;
                end
                else
                begin
                    pos_next = sldf_pkg::POS_BODY;
                end
            end
            else
            begin
                // Re-sync on the earliest later zero within the prefix
                priority if (prefix_reg[1] == 8'h00)
                begin
                    prefix_next[0] = prefix_reg[1];
                    prefix_next[1] = prefix_reg[2];
                    prefix_next[2] = prefix_reg[3];
                    prefix_next[3] = in_byte;
                    pos_next       = 3'd4;
                end
                else if (prefix_reg[2] == 8'h00)
                begin
                    prefix_next[0] = prefix_reg[2];
                    prefix_next[1] = prefix_reg[3];
                    prefix_next[2] = in_byte;
                    pos_next       = 3'd3;
                end
                else if (prefix_reg[3] == 8'h00)
                begin
                    prefix_next[0] = prefix_reg[3];
                    prefix_next[1] = in_byte;
                    pos_next       = 3'd2;
                end
                else if (in_byte == 8'h00)
                begin
                    prefix_next[0] = 8'h00;
                    pos_next       = 3'd1;
                end
                else
                begin
                    res_next.status     = sldf_pkg::STATUS_BAD_CMP;
                    res_next.err_first  = len_word;
                    res_next.err_second = cmp_word;
                    in_sync_next        = 1'b0;
                end
            end
        end
        else if (count_reg < len_reg)
        begin
            // Pass the payload byte out and fold it into the CRC
            res_next.payload_valid = 1'b1;
            res_next.payload_index = count_reg;
            res_next.payload_byte  = in_byte;
            count_next = count_reg + 16'd1;
            crc_next   = sldf_pkg::crc_step(crc_reg, in_byte);
        end
        else if (crc_cnt_reg == 2'd0)
        begin
            // Hold the CRC low byte
            crc_lo_next  = in_byte;
            crc_cnt_next = 2'd1;
        end
        else if (crc_cnt_reg == 2'd1)
        begin
            // Compare the received CRC and close the packet
            crc_cnt_next = 2'd2;
            in_sync_next = 1'b0;
            if (rx_crc != crc_reg)
            begin
                res_next.status     = sldf_pkg::STATUS_BAD_CRC;
                res_next.err_first  = rx_crc;
                res_next.err_second = crc_reg;
            end
            else
            begin
                res_next.status = sldf_pkg::STATUS_GOOD;
            end
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= sldf_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            max_length_reg <= cfg_data;
        end
    end

    // Advance the packet state on each taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sync_reg <= 1'b0;
            pos_reg     <= 3'd0;
            for (int k = 0; k < 4; k++)
            begin
                prefix_reg[k] <= 8'h00;
            end
            len_reg     <= 16'h0000;
            count_reg   <= 16'h0000;
            crc_reg     <= sldf_pkg::CRC_SEED;
            crc_lo_reg  <= 8'h00;
            crc_cnt_reg <= 2'd0;
        end
        else if (in_take)
        begin
            in_sync_reg <= in_sync_next;
            pos_reg     <= pos_next;
            for (int k = 0; k < 4; k++)
            begin
                prefix_reg[k] <= prefix_next[k];
            end
            len_reg     <= len_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            crc_lo_reg  <= crc_lo_next;
            crc_cnt_reg <= crc_cnt_next;
        end
    end

    // Result valid: load on take, drop once the receiver has it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### hw/rtl/sync_length_crc_packet_deframer.sv
// Top level of the sync/length/CRC packet deframer.
// Depends on sldf_pkg, sldf_in_stage and sldf_core.
//
// Usage:
//   s_* carries received bytes, one per beat (s_tdata = rx_byte).
//   m_* returns exactly one result beat per received byte, in order:
//   tuser flags payload bytes and carries the status code; tdata carries the
//   payload index and byte, or the two error words of an error status.
//   cfg_* writes max_length (largest accepted payload length), always
//   accepted; write it only while no byte is in flight.
// Path: a byte accepted on s_* passes the input register, then the result
//   register, before its result shows on m_*.
// Throughput: one byte per cycle while m_tready is high; the per-byte work (prefix check, 16-bit
//   length compare, one CRC byte update) fits between the two registers.
// Reset: clears the sync state and the packet counters, seeds the CRC, and sets
//   max_length to 1024; no result is pending afterward.
// Stall: when m_tready is low the result holds, the input register takes one
//   more byte if it is empty, then s_tready drops until the result is taken.
module sync_length_crc_packet_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side: tdata[7:0] = rx_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // master side: tdata[15:0] = payload_index, [23:16] = payload_byte,
    //              [39:24] = err_first, [55:40] = err_second
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    // tuser[0] = payload_valid, [3:1] = status
    output logic [3:0]  m_tuser,
    // configuration write: max_length
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic              in_valid;
    logic [7:0]        in_byte;
    logic              in_take;
    sldf_pkg::result_t res;

    assign cfg_ready = 1'b1;

    // Input register
    sldf_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_take  (in_take)
    );

    // Deframing logic and result register
    sldf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_take   (in_take),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result beat
    assign m_tdata = {res.err_second, res.err_first, res.payload_byte, res.payload_index};
    assign m_tuser = {res.status, res.payload_valid};

endmodule

### hw/rtl/sldf_checker.sv
// Port-level checks for the packet deframer, bound to its top level.
// Depends on sldf_pkg for the status codes.
module sldf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [3:0]  m_tuser
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // A payload beat carries no status
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[3:1] == sldf_pkg::STATUS_NONE)
        else $error("payload beat with status");

    // Status codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[3:1] <= sldf_pkg::STATUS_BAD_CRC)
        else $error("undefined status code");

    // Non-payload beats have zero index and byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'h000000)
        else $error("index or byte set on a non-payload beat");

    // Error words are zero unless an error status is reported
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[3:1] == sldf_pkg::STATUS_NONE ||
                     m_tuser[3:1] == sldf_pkg::STATUS_GOOD)
        |-> m_tdata[55:24] == 32'h00000000)
        else $error("error words set without an error status");

endmodule

bind sync_length_crc_packet_deframer sldf_checker u_sldf_checker (.*);
